>>> rtl/core/imp_pkg.sv
`default_nettype none
package imp_pkg;

  // store geometry
  localparam int STORE_DEPTH = 4096;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int COUNT_W     = $clog2(STORE_DEPTH + 1);

  // limits on the configured shape
  localparam int MAX_DIM     = 64;
  localparam int MAX_KERNEL  = 8;
  localparam int MAX_PLANES  = 2;

  localparam int VALUE_W     = 64;

  // configuration port
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 7;

  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_CHANNEL_COUNT = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_PLANE_COUNT   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_KERNEL_ROWS   = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_KERNEL_COLS   = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_STRIDE_ROWS   = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_STRIDE_COLS   = 3'd7;

  // input opcodes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EMIT = 1'b1;

  // commands from the front to the back
  localparam logic [1:0] CMD_WRITE     = 2'd0;
  localparam logic [1:0] CMD_READ      = 2'd1;
  localparam logic [1:0] CMD_NOT_READY = 2'd2;

  typedef struct packed {
    logic [1:0]         kind;
    logic               last;
    logic [ADDR_W-1:0]  addr;
    logic [VALUE_W-1:0] data;
  } cmd_t;

  // command queue
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCOUNT_W    = $clog2(QUEUE_DEPTH + 1);

endpackage
`default_nettype wire

>>> rtl/core/imp_ram.sv
`default_nettype none
module imp_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/imp_front.sv
`default_nettype none
module imp_front import imp_pkg::*; (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_valid,
  input  wire logic [CFG_INDEX_W-1:0]     cfg_index,
  input  wire logic [CFG_DATA_W-1:0]      cfg_data,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic                       opcode,
  input  wire logic signed [VALUE_W-1:0]  element_value,
  input  wire logic                       q_full,
  output logic                            push,
  output cmd_t                            push_cmd
);

  // raw registers
  logic [6:0] reg_h, reg_w, reg_c;
  logic [1:0] reg_p;
  logic [3:0] reg_kr, reg_kc, reg_sr, reg_sc;

  // clamped shape
  logic [6:0] h_eff, w_eff, c_eff;
  logic [1:0] p_eff;
  logic [3:0] kr_cl, kc_cl, kr_eff, kc_eff, sr_eff, sc_eff;
  logic [7:0] cp;

  // derived sizes, two register stages
  logic [11:0]       kcp_full, col_step_full;
  logic [14:0]       row_pitch_full;
  logic [20:0]       total_full;
  logic [17:0]       row_step_full;
  logic [10:0]       kcp;
  logic [13:0]       row_pitch;
  logic [ADDR_W-1:0] col_step, row_step;
  logic [20:0]       total;
  logic [1:0]        settle;

  // walk state
  logic [COUNT_W-1:0] load_count;
  logic [10:0]        elem;
  logic [2:0]         tap_row;
  logic [5:0]         col_base, row_base;
  logic [ADDR_W-1:0]  addr, tap_addr, win_addr, rowwin_addr;

  logic accept, cfg_write, image_ready, can_load;
  logic elem_wrap, tap_wrap, col_wrap, row_wrap, last;
  logic [ADDR_W-1:0] tap_next, win_next, rowwin_next;

  assign cfg_write = cfg_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      reg_h  <= 7'd1;
      reg_w  <= 7'd1;
      reg_c  <= 7'd1;
      reg_p  <= 2'd1;
      reg_kr <= 4'd1;
      reg_kc <= 4'd1;
      reg_sr <= 4'd1;
      reg_sc <= 4'd1;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_IMAGE_HEIGHT:  reg_h  <= cfg_data;
        REG_IMAGE_WIDTH:   reg_w  <= cfg_data;
        REG_CHANNEL_COUNT: reg_c  <= cfg_data;
        REG_PLANE_COUNT:   reg_p  <= cfg_data[1:0];
        REG_KERNEL_ROWS:   reg_kr <= cfg_data[3:0];
        REG_KERNEL_COLS:   reg_kc <= cfg_data[3:0];
        REG_STRIDE_ROWS:   reg_sr <= cfg_data[3:0];
        REG_STRIDE_COLS:   reg_sc <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    h_eff  = (reg_h == 7'd0) ? 7'd1 : ((reg_h > 7'(MAX_DIM)) ? 7'(MAX_DIM) : reg_h);
    w_eff  = (reg_w == 7'd0) ? 7'd1 : ((reg_w > 7'(MAX_DIM)) ? 7'(MAX_DIM) : reg_w);
    c_eff  = (reg_c == 7'd0) ? 7'd1 : ((reg_c > 7'(MAX_DIM)) ? 7'(MAX_DIM) : reg_c);
    p_eff  = (reg_p == 2'd0) ? 2'd1 : ((reg_p > 2'(MAX_PLANES)) ? 2'(MAX_PLANES) : reg_p);
    kr_cl  = (reg_kr == 4'd0) ? 4'd1 : ((reg_kr > 4'(MAX_KERNEL)) ? 4'(MAX_KERNEL) : reg_kr);
    kc_cl  = (reg_kc == 4'd0) ? 4'd1 : ((reg_kc > 4'(MAX_KERNEL)) ? 4'(MAX_KERNEL) : reg_kc);
    sr_eff = (reg_sr == 4'd0) ? 4'd1 : reg_sr;
    sc_eff = (reg_sc == 4'd0) ? 4'd1 : reg_sc;
    // kernel cut to the image
    kr_eff = ({3'b0, kr_cl} > h_eff) ? h_eff[3:0] : kr_cl;
    kc_eff = ({3'b0, kc_cl} > w_eff) ? w_eff[3:0] : kc_cl;
    // elements per pixel, planes are one or two
    cp     = (p_eff == 2'd2) ? {c_eff, 1'b0} : {1'b0, c_eff};
  end

  assign kcp_full       = {8'b0, kc_eff} * {4'b0, cp};
  assign row_pitch_full = {8'b0, w_eff} * {7'b0, cp};
  assign col_step_full  = {8'b0, sc_eff} * {4'b0, cp};
  assign total_full     = {14'b0, h_eff} * {7'b0, row_pitch};
  assign row_step_full  = {14'b0, sr_eff} * {4'b0, row_pitch};

  always_ff @(posedge clk) begin
    kcp       <= kcp_full[10:0];
    row_pitch <= row_pitch_full[13:0];
    col_step  <= ADDR_W'(col_step_full);
    total     <= total_full;
    row_step  <= ADDR_W'(row_step_full);
  end

  // hold off items until the derived sizes have caught up
  always_ff @(posedge clk) begin
    if (rst || cfg_write) begin
      settle <= 2'd2;
    end else if (settle != 2'd0) begin
      settle <= settle - 2'd1;
    end
  end

  assign in_ready = (settle == 2'd0) && !q_full;
  assign accept   = in_valid && in_ready;

  assign image_ready = (21'(load_count) == total) && (total <= 21'(STORE_DEPTH));
  assign can_load    = (21'(load_count) < total) && (load_count < COUNT_W'(STORE_DEPTH));

  assign elem_wrap = (elem + 11'd1) >= kcp;
  assign tap_wrap  = ({1'b0, tap_row} + 4'd1) >= kr_eff;
  assign col_wrap  = ({2'b0, col_base} + {4'b0, sc_eff} + {4'b0, kc_eff}) > {1'b0, w_eff};
  assign row_wrap  = ({2'b0, row_base} + {4'b0, sr_eff} + {4'b0, kr_eff}) > {1'b0, h_eff};
  assign last      = elem_wrap && tap_wrap && col_wrap && row_wrap;

  assign tap_next    = tap_addr + ADDR_W'(row_pitch);
  assign win_next    = win_addr + col_step;
  assign rowwin_next = rowwin_addr + row_step;

  always_comb begin
    push          = accept && ((opcode == OP_EMIT) || can_load);
    push_cmd.data = element_value;
    if (opcode == OP_LOAD) begin
      push_cmd.kind = CMD_WRITE;
      push_cmd.addr = load_count[ADDR_W-1:0];
      push_cmd.last = 1'b0;
    end else begin
      push_cmd.kind = image_ready ? CMD_READ : CMD_NOT_READY;
      push_cmd.addr = addr;
      push_cmd.last = image_ready && last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_write) begin
      load_count  <= '0;
      elem        <= '0;
      tap_row     <= '0;
      col_base    <= '0;
      row_base    <= '0;
      addr        <= '0;
      tap_addr    <= '0;
      win_addr    <= '0;
      rowwin_addr <= '0;
    end else if (accept) begin
      if (opcode == OP_LOAD) begin
        if (can_load) begin
          load_count <= load_count + COUNT_W'(1);
        end
      end else if (image_ready) begin
        priority if (!elem_wrap) begin
          elem <= elem + 11'd1;
          addr <= addr + ADDR_W'(1);
        end else if (!tap_wrap) begin
          elem     <= '0;
          tap_row  <= tap_row + 3'd1;
          tap_addr <= tap_next;
          addr     <= tap_next;
        end else if (!col_wrap) begin
          elem     <= '0;
          tap_row  <= '0;
          col_base <= col_base + {2'b0, sc_eff};
          win_addr <= win_next;
          tap_addr <= win_next;
          addr     <= win_next;
        end else if (!row_wrap) begin
          elem        <= '0;
          tap_row     <= '0;
          col_base    <= '0;
          row_base    <= row_base + {2'b0, sr_eff};
          rowwin_addr <= rowwin_next;
          win_addr    <= rowwin_next;
          tap_addr    <= rowwin_next;
          addr        <= rowwin_next;
        end else begin
          load_count  <= '0;
          elem        <= '0;
          tap_row     <= '0;
          col_base    <= '0;
          row_base    <= '0;
          addr        <= '0;
          tap_addr    <= '0;
          win_addr    <= '0;
          rowwin_addr <= '0;
        end
      end
    end
  end

  a_cfg_holds_input: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |=> !in_ready)
    else $error("item accepted right after a register write");

  a_load_count_bound: assert property (@(posedge clk) disable iff (rst)
    load_count <= COUNT_W'(STORE_DEPTH))
    else $error("load count ran past the store");

endmodule
`default_nettype wire

>>> rtl/core/imp_queue.sv
`default_nettype none
module imp_queue import imp_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  output logic      full,
  input  wire logic pop,
  output logic      head_valid,
  output cmd_t      head_cmd
);

  cmd_t                entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr, rd_ptr;
  logic [QCOUNT_W-1:0] count;

  assign full       = count == QCOUNT_W'(QUEUE_DEPTH);
  assign head_valid = count != '0;
  assign head_cmd   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCOUNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCOUNT_W'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full) && !(pop && !head_valid))
    else $error("command queue overflow or underflow");

endmodule
`default_nettype wire

>>> rtl/core/imp_back.sv
`default_nettype none
module imp_back import imp_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                head_valid,
  input  wire cmd_t                head_cmd,
  output logic                     pop,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic signed [VALUE_W-1:0] out_value,
  output logic                     status,
  output logic                     image_last
);

  logic               is_write, out_free;
  logic               wr_en, rd_en;
  logic [VALUE_W-1:0] rd_data;
  logic               s1_valid, s1_status, s1_last;

  assign is_write = head_cmd.kind == CMD_WRITE;
  assign out_free = !out_valid || out_ready;
  // a result command leaves only when the read stage and the output slot are free
  assign pop      = head_valid && (is_write || (!s1_valid && out_free));
  assign wr_en    = pop && is_write;
  assign rd_en    = pop && (head_cmd.kind == CMD_READ);

  imp_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (head_cmd.addr),
    .wr_data (head_cmd.data),
    .rd_en   (rd_en),
    .rd_addr (head_cmd.addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      s1_valid <= pop && !is_write;
      if (s1_valid) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_status <= head_cmd.kind != CMD_READ;
      s1_last   <= head_cmd.last;
    end
    if (s1_valid) begin
      out_value  <= s1_status ? '0 : rd_data;
      status     <= s1_status;
      image_last <= s1_last;
    end
  end

  a_slot_free: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> !out_valid)
    else $error("read data arrived while the output slot was full");

endmodule
`default_nettype wire

>>> rtl/core/im2row_patch_extractor.sv
// path: an accepted emit passes through the command queue, the store read stage and the output register
// throughput: loads one per cycle while in_ready is high; an emit's store read waits until
//   the read stage and the output register are both free, so emits do not overlap there
// reset: registers return to 1, counters clear, the image store keeps its contents;
//   input is held off after reset and after any register write until the derived sizes settle
`default_nettype none
module im2row_patch_extractor import imp_pkg::*; (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // configuration writes
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0]      cfg_index,
  input  wire logic [CFG_DATA_W-1:0]       cfg_data,
  // items in
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic                        opcode,
  input  wire logic signed [VALUE_W-1:0]   element_value,
  // results out
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic signed [VALUE_W-1:0]        out_value,
  output logic                             status,
  output logic                             image_last
);

  // register writes are always taken; the front restarts the image on each one
  assign cfg_ready = 1'b1;

  logic q_full, q_push, q_pop, q_head_valid;
  cmd_t q_push_cmd, q_head_cmd;

  // front: takes each transfer, keeps the load count and the window walk,
  // and turns the item into a store write, a store read or a not-ready reply, or drops a surplus load
  imp_front u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .opcode        (opcode),
    .element_value (element_value),
    .q_full        (q_full),
    .push          (q_push),
    .push_cmd      (q_push_cmd)
  );

  // short command queue that absorbs up to two commands while the output stalls
  imp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_cmd   (q_push_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_cmd   (q_head_cmd)
  );

  // back: owns the image store, runs commands in order, so a write always
  // lands before any later read of the same entry, and registers the result
  imp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (q_head_valid),
    .head_cmd   (q_head_cmd),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_value  (out_value),
    .status     (status),
    .image_last (image_last)
  );

endmodule
`default_nettype wire

>>> sim/im2row_patch_extractor_test.sv
`timescale 1ns / 100ps

module im2row_patch_extractor_test;
  import imp_pkg::*;

  // stride registers hold 4 bits, so a stride saturates at 15 rather than at MAX_KERNEL
  localparam int STRIDE_MAX    = 15;
  // idle wait before each register write, as a margin after the last result
  localparam int SETTLE_CYCLES = 6;
  localparam int TAIL_CYCLES   = 20;
  localparam int RANDOM_ITEMS  = 300;
  // random shapes stay small so that each image is quick to load and drain
  localparam int RAND_IMAGE_MAX = 256;
  localparam int RAND_PATCH_MAX = 160;
  localparam int TIMEOUT_NS    = 6_000_000;

  // one reshaped element as it leaves the block
  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      status;
    logic                      last;
  } elem_t;

  // raw register contents and the shape they decode to
  typedef logic [7:0][CFG_DATA_W-1:0] shape_regs_t;
  typedef struct packed {
    int h, w, c, p, kr, kc, sr, sc;
  } dims_t;

  // one row of the directed table: a register write or an item, with an
  // optional hand-typed result
  typedef struct packed {
    bit                     is_cfg;
    logic [CFG_INDEX_W-1:0] idx;
    logic [CFG_DATA_W-1:0]  data;
    logic                   op;
    logic [VALUE_W-1:0]     val;
    bit                     typed;
    elem_t                  want;
  } stim_row_t;

  // clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // every input known from time zero
  logic                        cfg_valid     = 1'b0;
  logic [CFG_INDEX_W-1:0]      cfg_index     = '0;
  logic [CFG_DATA_W-1:0]       cfg_data      = '0;
  logic                        in_valid      = 1'b0;
  logic                        opcode        = OP_LOAD;
  logic signed [VALUE_W-1:0]   element_value = '0;
  logic                        out_ready     = 1'b0;
  logic                        cfg_ready;
  logic                        in_ready;
  logic                        out_valid;
  logic signed [VALUE_W-1:0]   out_value;
  logic                        status;
  logic                        image_last;

  im2row_patch_extractor dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .opcode        (opcode),
    .element_value (element_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_value     (out_value),
    .status        (status),
    .image_last    (image_last)
  );

  // ---------------------------------------------------------------------------
  // behavioural copy of the block: registers, image store and window counters
  // ---------------------------------------------------------------------------
  shape_regs_t        shape_reg;
  dims_t              shape;
  logic [VALUE_W-1:0] image_mem [STORE_DEPTH];
  int                 loaded;
  int                 win_r, win_c, tap_r, tap_c, chan, plane;
  bit                 image_done;

  // elements still owed by the block, oldest first
  elem_t awaited_elems[$];

  int accepted_items  = 0;
  int useful_items    = 0;
  int results_checked = 0;
  int reg_writes      = 0;
  int mismatches      = 0;

  // zero reads as one, anything above the limit saturates
  function automatic int clamp_dim(int v, int hi);
    if (v == 0) return 1;
    return (v > hi) ? hi : v;
  endfunction

  // bits of each register that are actually kept
  function automatic logic [CFG_DATA_W-1:0] field_mask(logic [CFG_INDEX_W-1:0] idx);
    case (idx)
      REG_PLANE_COUNT: return 7'h03;
      REG_KERNEL_ROWS, REG_KERNEL_COLS, REG_STRIDE_ROWS, REG_STRIDE_COLS: return 7'h0F;
      default: return 7'h7F;
    endcase
  endfunction

  function automatic dims_t decode_shape(shape_regs_t r);
    dims_t d;
    d.h  = clamp_dim(int'(r[REG_IMAGE_HEIGHT]), MAX_DIM);
    d.w  = clamp_dim(int'(r[REG_IMAGE_WIDTH]), MAX_DIM);
    d.c  = clamp_dim(int'(r[REG_CHANNEL_COUNT]), MAX_DIM);
    d.p  = clamp_dim(int'(r[REG_PLANE_COUNT]), MAX_PLANES);
    d.kr = clamp_dim(int'(r[REG_KERNEL_ROWS]), MAX_KERNEL);
    d.kc = clamp_dim(int'(r[REG_KERNEL_COLS]), MAX_KERNEL);
    d.sr = clamp_dim(int'(r[REG_STRIDE_ROWS]), STRIDE_MAX);
    d.sc = clamp_dim(int'(r[REG_STRIDE_COLS]), STRIDE_MAX);
    // kernel never wider or taller than the image
    if (d.kr > d.h) d.kr = d.h;
    if (d.kc > d.w) d.kc = d.w;
    return d;
  endfunction

  function automatic int image_elems(dims_t d);
    return d.h * d.w * d.c * d.p;
  endfunction

  // elements in the whole reshaped output of one image
  function automatic int patch_elems(dims_t d);
    return ((d.h - d.kr) / d.sr + 1) * ((d.w - d.kc) / d.sc + 1) * d.kr * d.kc * d.c * d.p;
  endfunction

  function automatic void restart_image();
    loaded     = 0;
    win_r      = 0;
    win_c      = 0;
    tap_r      = 0;
    tap_c      = 0;
    chan       = 0;
    plane      = 0;
    image_done = 1'b0;
  endfunction

  // any register write restarts the current image
  function automatic void apply_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    shape_reg[idx] = data & field_mask(idx);
    shape          = decode_shape(shape_reg);
    restart_image();
  endfunction

  // advance the copy by one accepted item; an emit always yields one element
  function automatic void next_patch_elem(input logic op, input logic [VALUE_W-1:0] val,
                                          output bit made, output elem_t res);
    int row, col, addr;
    made = 1'b0;
    res  = '0;
    if (op == OP_LOAD) begin
      // first load after a finished image opens a new one
      if (image_done) restart_image();
      // surplus loads, and loads past the end of the store, are dropped
      if (loaded < image_elems(shape) && loaded < STORE_DEPTH) begin
        image_mem[ADDR_W'(loaded)] = val;
        loaded++;
        useful_items++;
      end
      return;
    end
    made = 1'b1;
    useful_items++;
    // not ready: image incomplete, already finished, or too big for the store
    if (image_done || image_elems(shape) > STORE_DEPTH || loaded < image_elems(shape)) begin
      res.status = 1'b1;
      return;
    end
    row  = win_r * shape.sr + tap_r;
    col  = win_c * shape.sc + tap_c;
    addr = ((row * shape.w + col) * shape.c + chan) * shape.p + plane;
    res.value = (addr < STORE_DEPTH) ? image_mem[ADDR_W'(addr)] : '0;
    // loop order: window row, window column, tap row, tap column, channel, plane
    plane++;
    if (plane >= shape.p) begin
      plane = 0;
      chan++;
      if (chan >= shape.c) begin
        chan = 0;
        tap_c++;
        if (tap_c >= shape.kc) begin
          tap_c = 0;
          tap_r++;
          if (tap_r >= shape.kr) begin
            tap_r = 0;
            win_c++;
            if (win_c >= (shape.w - shape.kc) / shape.sc + 1) begin
              win_c = 0;
              win_r++;
              if (win_r >= (shape.h - shape.kr) / shape.sr + 1) begin
                res.last = 1'b1;
                restart_image();
                image_done = 1'b1;
              end
            end
          end
        end
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // result side: stall pattern and checker
  // ---------------------------------------------------------------------------
  int ready_mode = 0;
  int ready_left = 0;

  // modes last a random while: always ready, coin toss, or mostly stalled
  always @(negedge clk) begin
    if (ready_left == 0) begin
      ready_mode = $urandom_range(0, 2);
      ready_left = $urandom_range(16, 200);
    end else begin
      ready_left--;
    end
    case (ready_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      default: out_ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // every result transfer is matched against the oldest owed element
  always @(posedge clk) begin : result_check
    elem_t seen, want;
    if (!rst && out_valid && out_ready) begin
      seen = {out_value, status, image_last};
      if (awaited_elems.size() == 0) begin
        $display("%0t: unexpected result: value %h status %b last %b",
                 $time, seen.value, seen.status, seen.last);
        mismatches++;
      end else begin
        want = awaited_elems.pop_front();
        results_checked++;
        if (seen.value !== want.value) begin
          $display("%0t: out_value expected %h actual %h", $time, want.value, seen.value);
          mismatches++;
        end
        if (seen.status !== want.status) begin
          $display("%0t: status expected %b actual %b", $time, want.status, seen.status);
          mismatches++;
        end
        if (seen.last !== want.last) begin
          $display("%0t: image_last expected %b actual %b", $time, want.last, seen.last);
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // item side: bursty sender, register writes and idle waits
  // every task is entered and left at a falling edge
  // ---------------------------------------------------------------------------
  int burst_left = 0;

  function automatic logic [VALUE_W-1:0] any_value();
    return {$urandom, $urandom};
  endfunction

  // one item transfer; valid stays high into the next item unless a gap starts
  task automatic send_item(input logic op, input logic [VALUE_W-1:0] val,
                           input bit typed = 1'b0, input elem_t want = '0);
    bit    made;
    elem_t res;
    int    gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                               : $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid      <= 1'b1;
    opcode        <= op;
    element_value <= val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    accepted_items++;
    next_patch_elem(op, val, made, res);
    // hand-typed rows override the copy, which still tracks the state
    if (made) awaited_elems.push_back(typed ? want : res);
    @(negedge clk);
  endtask

  // drop valid and hold until every owed element has arrived
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (awaited_elems.size() != 0);
  endtask

  // loads give no result, so allow the pipeline to settle before a write
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_reg(idx, data);
    reg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_shape(input shape_regs_t r);
    for (int i = 0; i < 8; i++) write_reg(CFG_INDEX_W'(i), r[CFG_INDEX_W'(i)]);
  endtask

  // mostly small legal values, sometimes zero, all ones or any raw pattern
  function automatic logic [CFG_DATA_W-1:0] random_reg(logic [CFG_INDEX_W-1:0] idx);
    int pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    if (pick == 2) return CFG_DATA_W'($urandom_range(0, 127));
    case (idx)
      REG_PLANE_COUNT: return CFG_DATA_W'($urandom_range(1, 2));
      REG_KERNEL_ROWS, REG_KERNEL_COLS, REG_STRIDE_ROWS, REG_STRIDE_COLS:
        return CFG_DATA_W'($urandom_range(1, 3));
      default: return CFG_DATA_W'($urandom_range(1, 5));
    endcase
  endfunction

  // one well-formed image with random content, salted with early emits,
  // surplus loads, a pause and an emit after the end; stop_after > 0 cuts it short
  task automatic run_image(input int stop_after);
    int total, outs, sent;
    total = image_elems(shape);
    outs  = patch_elems(shape);
    sent  = 0;
    for (int k = 0; k < total; k++) begin
      if ($urandom_range(0, 24) == 0) send_item(OP_EMIT, any_value());
      send_item(OP_LOAD, any_value());
      sent++;
      if (sent == stop_after) return;
    end
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 3)) send_item(OP_LOAD, any_value());
    end
    if ($urandom_range(0, 9) == 0) wait_drained();
    for (int k = 0; k < outs; k++) begin
      send_item(OP_EMIT, any_value());
      sent++;
      if (sent == stop_after) return;
    end
    if ($urandom_range(0, 4) == 0) send_item(OP_EMIT, any_value());
  endtask

  // directed table helpers
  function automatic stim_row_t cfg_row(logic [CFG_INDEX_W-1:0] idx,
                                        logic [CFG_DATA_W-1:0] data);
    stim_row_t r;
    r        = '0;
    r.is_cfg = 1'b1;
    r.idx    = idx;
    r.data   = data;
    return r;
  endfunction

  function automatic stim_row_t load_row(logic [VALUE_W-1:0] val);
    stim_row_t r;
    r     = '0;
    r.op  = OP_LOAD;
    r.val = val;
    return r;
  endfunction

  function automatic stim_row_t emit_chk(logic [VALUE_W-1:0] v, logic s, logic l);
    stim_row_t r;
    r       = '0;
    r.op    = OP_EMIT;
    r.typed = 1'b1;
    r.want  = {v, s, l};
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // run
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    stim_row_t   directed[$];
    shape_regs_t big;
    shape_regs_t cand;
    int          random_start;
    int          n_img;
    int          stop;

    // copy starts at the reset state: every register reads one
    for (int i = 0; i < 8; i++) shape_reg[CFG_INDEX_W'(i)] = 7'd1;
    shape = decode_shape(shape_reg);
    restart_image();

    // emit straight after reset, then a 1x1x1x1 image with surplus load and
    // emit after the end, then a second image reopening after completion
    directed.push_back(emit_chk(64'h0, 1'b1, 1'b0));
    directed.push_back(load_row(64'h7FFF_FFFF_FFFF_FFFF));
    directed.push_back(load_row(64'h0000_0000_0000_1234));
    directed.push_back(emit_chk(64'h7FFF_FFFF_FFFF_FFFF, 1'b0, 1'b1));
    directed.push_back(emit_chk(64'h0, 1'b1, 1'b0));
    directed.push_back(load_row(64'h8000_0000_0000_0000));
    directed.push_back(emit_chk(64'h8000_0000_0000_0000, 1'b0, 1'b1));
    // plane count written all ones: masked to 3, saturates at two planes;
    // emit halfway through the load is not ready
    directed.push_back(cfg_row(REG_PLANE_COUNT, 7'h7F));
    directed.push_back(load_row(64'hFFFF_FFFF_FFFF_FFFF));
    directed.push_back(emit_chk(64'h0, 1'b1, 1'b0));
    directed.push_back(load_row(64'h0));
    directed.push_back(emit_chk(64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0));
    directed.push_back(emit_chk(64'h0, 1'b0, 1'b1));
    // 2x2 image, kernel rows saturate to 8 and are cut to 2, zero reads as one,
    // column stride saturates at 15: one window, picks (0,0) then (1,0)
    directed.push_back(cfg_row(REG_PLANE_COUNT, 7'd1));
    directed.push_back(cfg_row(REG_IMAGE_HEIGHT, 7'd2));
    directed.push_back(cfg_row(REG_IMAGE_WIDTH, 7'd2));
    directed.push_back(cfg_row(REG_KERNEL_ROWS, 7'h7F));
    directed.push_back(cfg_row(REG_KERNEL_COLS, 7'd0));
    directed.push_back(cfg_row(REG_STRIDE_ROWS, 7'd0));
    directed.push_back(cfg_row(REG_STRIDE_COLS, 7'h7F));
    directed.push_back(load_row(64'hA5A5_A5A5_0000_0001));
    directed.push_back(load_row(64'h5A5A_5A5A_0000_0002));
    directed.push_back(load_row(64'hC3C3_C3C3_0000_0003));
    directed.push_back(load_row(64'h3C3C_3C3C_0000_0004));
    directed.push_back(emit_chk(64'hA5A5_A5A5_0000_0001, 1'b0, 1'b0));
    directed.push_back(emit_chk(64'hC3C3_C3C3_0000_0003, 1'b0, 1'b1));
    // a register write halfway through the output throws the image away
    directed.push_back(load_row(64'h0F0F_0F0F_F0F0_F0F0));
    directed.push_back(load_row(64'hF0F0_F0F0_0F0F_0F0F));
    directed.push_back(load_row(64'h0123_4567_89AB_CDEF));
    directed.push_back(load_row(64'hFEDC_BA98_7654_3210));
    directed.push_back(emit_chk(64'h0F0F_0F0F_F0F0_F0F0, 1'b0, 1'b0));
    directed.push_back(cfg_row(REG_CHANNEL_COUNT, 7'h7F));
    directed.push_back(emit_chk(64'h0, 1'b1, 1'b0));

    // hold synchronous reset, then release it at a falling edge
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    foreach (directed[i]) begin
      if (directed[i].is_cfg) write_reg(directed[i].idx, directed[i].data);
      else send_item(directed[i].op, directed[i].val, directed[i].typed, directed[i].want);
    end

    // 16x16 image, strides of 15 reach its far corner
    big[REG_IMAGE_HEIGHT]  = 7'd16;
    big[REG_IMAGE_WIDTH]   = 7'd16;
    big[REG_CHANNEL_COUNT] = 7'd1;
    big[REG_PLANE_COUNT]   = 7'd1;
    big[REG_KERNEL_ROWS]   = 7'd0;
    big[REG_KERNEL_COLS]   = 7'd1;
    big[REG_STRIDE_ROWS]   = 7'd15;
    big[REG_STRIDE_COLS]   = 7'h7F;
    load_shape(big);
    run_image(0);

    // 64x64 with two planes is twice the store: emits are never ready
    write_reg(REG_IMAGE_HEIGHT, 7'h7F);
    write_reg(REG_IMAGE_WIDTH, 7'd64);
    write_reg(REG_PLANE_COUNT, 7'd2);
    repeat (16) send_item(OP_LOAD, any_value());
    repeat (3) send_item(OP_EMIT, any_value());

    // random shapes, each with a few images; the last one is sometimes cut
    // short so that the next register write lands mid-image
    random_start = useful_items;
    while (useful_items - random_start < RANDOM_ITEMS) begin
      do begin
        for (int i = 0; i < 8; i++) cand[CFG_INDEX_W'(i)] = random_reg(CFG_INDEX_W'(i));
      end while (image_elems(decode_shape(cand)) > RAND_IMAGE_MAX ||
                 patch_elems(decode_shape(cand)) > RAND_PATCH_MAX);
      load_shape(cand);
      // now and then a burst of noise before the images
      if ($urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(4, 16)) send_item(1'($urandom_range(0, 1)), any_value());
      end
      n_img = $urandom_range(1, 3);
      for (int img = 0; img < n_img; img++) begin
        stop = 0;
        if (img == n_img - 1 && $urandom_range(0, 3) == 0) begin
          stop = $urandom_range(1, image_elems(shape) + patch_elems(shape));
        end
        run_image(stop);
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk);
    $display("run: %0d item transfers (%0d stored or emitted), %0d register writes",
             accepted_items, useful_items, reg_writes);
    $display("run: %0d results checked, shapes from 1x1 to 16x16 and one too big for the store, "
             , results_checked, "%0d mismatches", mismatches);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // safety net against a hung handshake
  initial begin : watchdog
    #TIMEOUT_NS;
    $display("timeout with %0d results outstanding", awaited_elems.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule
